### rtl/itrd_pkg.sv
// Shared types, constants and helpers for the integer to radix digit converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package itrd_pkg;

   localparam int VALUE_BITS_DEFAULT = 31;
   localparam int MAX_DIGITS_DEFAULT = 31;

   localparam int RADIX_BITS = 5;
   localparam int DIGIT_BITS = 4;
   localparam int CHAR_BITS  = 7;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;

   localparam logic [DIGIT_BITS-1:0] DECIMAL_LIMIT = 4'd10;
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO     = 7'd48;
   localparam logic [CHAR_BITS-1:0]  CHAR_LETTER   = 7'd55;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DIVIDE   = 5'b00010,
      ST_STORE    = 5'b00100,
      ST_READ     = 5'b01000,
      ST_PRESENT  = 5'b10000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic store;
      logic emit_start;
      logic emit_next;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
      logic quot_zero;
      logic count_full;
      logic idx_zero;
   } status_type;

   function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] raw);
      logic [RADIX_BITS-1:0] res;
      if (raw < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (raw > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = raw;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] res;
      if (d < DECIMAL_LIMIT) begin
         res = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         res = CHAR_LETTER + CHAR_BITS'(d);
      end
      return res;
   endfunction

endpackage

### rtl/itrd_ctrl.sv
// Sequencing state machine: divide, store each remainder, then emit digits.
// Depends on itrd_pkg; drives the datapath through cmd_type, reads status_type.
`timescale 1ns / 1ps

module itrd_ctrl
   import itrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_PRESENT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            // stop once the quotient is exhausted or the store is full
            if (status.quot_zero || status.count_full) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_READ;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_READ: begin
            state_in = ST_PRESENT;
         end
         ST_PRESENT: begin
            if (rsp_tready) begin
               if (status.idx_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/itrd_datapath.sv
// Bit-serial restoring divider by the radix, digit store and emission read port.
// Depends on itrd_pkg; commanded by itrd_ctrl.
`timescale 1ns / 1ps

module itrd_datapath
   import itrd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [VALUE_BITS-1:0] value,
   input  logic [RADIX_BITS-1:0] radix,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [DIGIT_BITS-1:0] digit,
   output logic [CHAR_BITS-1:0]  digit_char,
   output logic                  last
);

   localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [VALUE_BITS-1:0] quot_ff;
   logic [DIGIT_BITS-1:0] rem_ff;
   logic [RADIX_BITS-1:0] radix_ff;
   logic [BW-1:0]         bit_cnt_ff;
   logic [IW-1:0]         cnt_ff;
   logic [IW-1:0]         idx_ff;
   logic [DIGIT_BITS-1:0] rd_data_ff;
   logic [DIGIT_BITS-1:0] store_mem [MAX_DIGITS];

   logic [RADIX_BITS-1:0] shifted;
   logic                  fits;
   logic [DIGIT_BITS-1:0] rem_in;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   assign shifted = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign fits    = (shifted >= radix_ff);
   assign rem_in  = fits ? DIGIT_BITS'(shifted - radix_ff) : DIGIT_BITS'(shifted);

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= '0;
         cnt_ff     <= '0;
         idx_ff     <= '0;
         radix_ff   <= RADIX_MIN;
      end else begin
         if (cmd.load) begin
            bit_cnt_ff <= '0;
            cnt_ff     <= '0;
            radix_ff   <= clamp_radix(radix);
         end else if (cmd.div_step) begin
            bit_cnt_ff <= bit_cnt_ff + BW'(1);
         end else if (cmd.store) begin
            bit_cnt_ff <= '0;
            cnt_ff     <= cnt_ff + IW'(1);
         end
         if (cmd.emit_start) begin
            idx_ff <= cnt_ff;
         end else if (cmd.emit_next) begin
            idx_ff <= idx_ff - IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff <= value;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[VALUE_BITS-2:0], fits};
         rem_ff  <= rem_in;
      end else if (cmd.store) begin
         rem_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         store_mem[cnt_ff] <= rem_ff;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

   assign status.div_done   = (bit_cnt_ff == BW'(VALUE_BITS - 1));
   assign status.quot_zero  = (quot_ff == '0);
   assign status.count_full = (cnt_ff == IW'(MAX_DIGITS - 1));
   assign status.idx_zero   = (idx_ff == '0);

   assign digit      = rd_data_ff;
   assign digit_char = digit_ascii(rd_data_ff);
   assign last       = (idx_ff == '0);

endmodule

### rtl/integer_to_radix_digits.sv
// Integer to radix digits: unsigned value to digits in radix 2..16, most significant first.
// Uses itrd_pkg, itrd_ctrl and itrd_datapath.
// Division runs one restoring step per cycle over all VALUE_BITS dividend bits for each digit,
// then stores the remainder; digits are then emitted through the registered store read.
// Throughput: one transaction in flight at a time.
// Reset: synchronous, active high; radix returns to 10, controller to idle.
`timescale 1ns / 1ps

module integer_to_radix_digits
   import itrd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: value [VALUE_BITS-1:0], zero padding above
   input  logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: digit [3:0], digit_char [10:4], zeros [15:11]
   output logic [RSP_DATA_BITS-1:0]            rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // radix register write
   input  logic [RADIX_BITS-1:0]               csr_data,
   input  logic                                csr_valid,
   output logic                                csr_ready
);

   logic [RADIX_BITS-1:0] radix_ff;
   cmd_type               cmd;
   status_type            status;
   logic [DIGIT_BITS-1:0] digit;
   logic [CHAR_BITS-1:0]  digit_char;
   logic                  last;

   // Radix register: always writable; sampled (and clamped) when a value is taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid) begin
         radix_ff <= csr_data;
      end
   end

   // Controller: owns both handshakes and sequences the datapath
   itrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: divider, digit store and output formatting
   itrd_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata[VALUE_BITS-1:0]),
      .radix      (radix_ff),
      .cmd        (cmd),
      .status     (status),
      .digit      (digit),
      .digit_char (digit_char),
      .last       (last)
   );

   // Hold the digit from the registered store read for as long as it is offered
   assign rsp_tdata = {{(RSP_DATA_BITS - DIGIT_BITS - CHAR_BITS){1'b0}}, digit_char, digit};
   assign rsp_tlast = last;

   // Never take a new value while digits of the previous one are still offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a digit is pending");

   // Character code must match the digit value
   a_char_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((digit < DECIMAL_LIMIT && digit_char == CHAR_ZERO + CHAR_BITS'(digit)) ||
                      (digit >= DECIMAL_LIMIT && digit_char == CHAR_LETTER + CHAR_BITS'(digit))))
      else $error("digit character mismatch");

   // The final digit of a run returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not idle after final digit");

   // The datapath gets no load, divide step or store while digits are offered
   a_no_step_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(cmd.div_step || cmd.store || cmd.load))
      else $error("datapath commanded during emission");

endmodule
